// ===== sv/point_in_triangle_3d_test_defines.svh =====
// assertion macros shared by the point-in-triangle checker
// no dependencies; include by bare file name
`ifndef POINT_IN_TRIANGLE_3D_TEST_DEFINES_SVH
`define POINT_IN_TRIANGLE_3D_TEST_DEFINES_SVH

// same-cycle implication, off while reset is low
`define PIT3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pit3 check failed");

// next-cycle implication, off while reset is low
`define PIT3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pit3 check failed");

`endif

// ===== sv/pit3_pkg.sv =====
// shared constants and types for the point-in-triangle test
// no dependencies
package pit3_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int NUM_FIELDS      = 12;
	localparam int OUT_TDATA_W     = 8;

	// bit positions in the result tdata
	localparam int OUT_INSIDE = 0;
	localparam int OUT_BC     = 1;
	localparam int OUT_AC     = 2;
	localparam int OUT_AB     = 3;

	// per-stage load enables for the side test units
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pit3_stage_en_t;

endpackage

// ===== sv/point_in_triangle_3d_test.sv =====
// point-in-triangle same-side test in 3D, top level
// depends on pit3_pkg and pit3_side
//
// channel   dir  fields
// s_*       in   tdata: point xyz, corner a xyz, corner b xyz, corner c xyz
// m_*       out  tdata: inside_res, side_bc_ok, side_ac_ok, side_ab_ok
//
// six register stages: differences, cross terms, cross products,
// dot partial products, per-axis products, dot sum and sign
// one transfer per cycle in and out while m_tready does not stall the output
// reset clears the stage valid bits only
// each stage holds while the one after it is full and held; a stall
// at m_tready backs up stage by stage, bubbles still close up
module point_in_triangle_3d_test #(
	parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF,
	localparam int InTdataW = ((pit3_pkg::NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// point_x, point_y, point_z, corner_a_x..z, corner_b_x..z, corner_c_x..z,
	// each COORD_WIDTH bits signed, zero padded to whole bytes
	input  logic [InTdataW-1:0]               s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// inside_res, side_bc_ok, side_ac_ok, side_ab_ok, then four zero bits
	output logic [pit3_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import pit3_pkg::*;

	localparam int DW = COORD_WIDTH + 1;

	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [COORD_WIDTH-1:0] ca [3];
	logic signed [COORD_WIDTH-1:0] cb [3];
	logic signed [COORD_WIDTH-1:0] cc [3];

	// edge order: bc, ac, ab
	logic signed [DW-1:0] dv_s1 [3][3];
	logic signed [DW-1:0] qv_s1 [3][3];
	logic signed [DW-1:0] sv_s1 [3][3];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1;
	pit3_stage_en_t en;
	logic [2:0] same_s6;

	assign en.s6  = ~valid_s6 | m_tready;
	assign en.s5  = ~valid_s5 | en.s6;
	assign en.s4  = ~valid_s4 | en.s5;
	assign en.s3  = ~valid_s3 | en.s4;
	assign en.s2  = ~valid_s2 | en.s3;
	assign en_s1  = ~valid_s1 | en.s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
			ca[i] = s_tdata[(3+i)*COORD_WIDTH +: COORD_WIDTH];
			cb[i] = s_tdata[(6+i)*COORD_WIDTH +: COORD_WIDTH];
			cc[i] = s_tdata[(9+i)*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	// edge vector and the two offsets from the edge's first corner
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 3; i++) begin
				dv_s1[0][i] <= DW'(cc[i]) - DW'(cb[i]);
				qv_s1[0][i] <= DW'(pt[i]) - DW'(cb[i]);
				sv_s1[0][i] <= DW'(ca[i]) - DW'(cb[i]);
				dv_s1[1][i] <= DW'(cc[i]) - DW'(ca[i]);
				qv_s1[1][i] <= DW'(pt[i]) - DW'(ca[i]);
				sv_s1[1][i] <= DW'(cb[i]) - DW'(ca[i]);
				dv_s1[2][i] <= DW'(cb[i]) - DW'(ca[i]);
				qv_s1[2][i] <= DW'(pt[i]) - DW'(ca[i]);
				sv_s1[2][i] <= DW'(cc[i]) - DW'(ca[i]);
			end
		end
	end

	for (genvar e = 0; e < 3; e++) begin : g_side
		pit3_side #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_side (
			.clk     (clk),
			.en      (en),
			.dv_s1   (dv_s1[e]),
			.qv_s1   (qv_s1[e]),
			.sv_s1   (sv_s1[e]),
			.same_s6 (same_s6[e])
		);
	end

	assign m_tvalid = valid_s6;

	always_comb begin
		m_tdata             = '0;
		m_tdata[OUT_INSIDE] = &same_s6;
		m_tdata[OUT_BC]     = same_s6[0];
		m_tdata[OUT_AC]     = same_s6[1];
		m_tdata[OUT_AB]     = same_s6[2];
	end

endmodule

// ===== sv/pit3_side.sv =====
// one same-side test: two cross products, their dot product, sign flag
// stages s2..s6; depends on pit3_pkg
module pit3_side #(
	parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  pit3_pkg::pit3_stage_en_t      en,
	input  logic signed [COORD_WIDTH:0]   dv_s1 [3],
	input  logic signed [COORD_WIDTH:0]   qv_s1 [3],
	input  logic signed [COORD_WIDTH:0]   sv_s1 [3],
	output logic                          same_s6
);
	import pit3_pkg::*;

	localparam int DW   = COORD_WIDTH + 1;
	localparam int PW   = 2 * DW;
	localparam int CW   = 2 * COORD_WIDTH + 3;
	localparam int H    = (CW + 1) / 2;
	localparam int HIW  = CW - H;
	localparam int DTW  = 2 * CW;
	localparam int SUMW = DTW + 2;

	// cross product terms: index 2k and 2k+1 form component k
	logic signed [PW-1:0]  pq_s2 [6];
	logic signed [PW-1:0]  ps_s2 [6];
	logic signed [CW-1:0]  c1_s3 [3];
	logic signed [CW-1:0]  c2_s3 [3];

	// partial products of the dot product, per axis
	logic signed [2*HIW-1:0]   hh_s4 [3];
	logic signed [HIW+H:0]     hl_s4 [3];
	logic signed [HIW+H:0]     lh_s4 [3];
	logic        [2*H-1:0]     ll_s4 [3];
	logic signed [DTW-1:0]     prod_s5 [3];

	logic signed [HIW-1:0] a_hi [3];
	logic signed [HIW-1:0] b_hi [3];
	logic signed [H:0]     a_lo [3];
	logic signed [H:0]     b_lo [3];
	logic signed [SUMW-1:0] dot;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pq_s2[0] <= dv_s1[1] * qv_s1[2];
			pq_s2[1] <= dv_s1[2] * qv_s1[1];
			pq_s2[2] <= dv_s1[2] * qv_s1[0];
			pq_s2[3] <= dv_s1[0] * qv_s1[2];
			pq_s2[4] <= dv_s1[0] * qv_s1[1];
			pq_s2[5] <= dv_s1[1] * qv_s1[0];
			ps_s2[0] <= dv_s1[1] * sv_s1[2];
			ps_s2[1] <= dv_s1[2] * sv_s1[1];
			ps_s2[2] <= dv_s1[2] * sv_s1[0];
			ps_s2[3] <= dv_s1[0] * sv_s1[2];
			ps_s2[4] <= dv_s1[0] * sv_s1[1];
			ps_s2[5] <= dv_s1[1] * sv_s1[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < 3; k++) begin
				c1_s3[k] <= CW'(pq_s2[2*k]) - CW'(pq_s2[2*k+1]);
				c2_s3[k] <= CW'(ps_s2[2*k]) - CW'(ps_s2[2*k+1]);
			end
		end
	end

	// split each cross component into a signed high part and an unsigned low part
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_hi[k] = c1_s3[k][CW-1:H];
			b_hi[k] = c2_s3[k][CW-1:H];
			a_lo[k] = $signed({1'b0, c1_s3[k][H-1:0]});
			b_lo[k] = $signed({1'b0, c2_s3[k][H-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < 3; k++) begin
				hh_s4[k] <= a_hi[k] * b_hi[k];
				hl_s4[k] <= a_hi[k] * b_lo[k];
				lh_s4[k] <= a_lo[k] * b_hi[k];
				ll_s4[k] <= c1_s3[k][H-1:0] * c2_s3[k][H-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int k = 0; k < 3; k++) begin
				prod_s5[k] <= (DTW'(hh_s4[k]) <<< (2 * H))
					+ ((DTW'(hl_s4[k]) + DTW'(lh_s4[k])) <<< H)
					+ DTW'({1'b0, ll_s4[k]});
			end
		end
	end

	assign dot = SUMW'(prod_s5[0]) + SUMW'(prod_s5[1]) + SUMW'(prod_s5[2]);

	// zero counts as the same side, so boundary points pass
	always_ff @(posedge clk) begin
		if (en.s6) begin
			same_s6 <= ~dot[SUMW-1];
		end
	end

endmodule

// ===== sv/pit3_checker.sv =====
// port-level checks for the point-in-triangle test, bound to the top level
// depends on pit3_pkg and point_in_triangle_3d_test_defines.svh
`include "point_in_triangle_3d_test_defines.svh"

module pit3_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pit3_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import pit3_pkg::*;

	logic edges_all;

	assign edges_all = m_tdata[OUT_BC] & m_tdata[OUT_AC] & m_tdata[OUT_AB];

	// a held result stays up and unchanged
	`PIT3_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`PIT3_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// overall flag is the and of the edge flags
	`PIT3_ASSERT_NOW(a_inside_and, clk, arst_n, m_tvalid, m_tdata[OUT_INSIDE] == edges_all)
	// padding above the flags is zero
	`PIT3_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:OUT_AB+1] == '0)
	// an empty output stage means the pipe can take a transfer
	`PIT3_ASSERT_NOW(a_ready_empty, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind point_in_triangle_3d_test pit3_checker u_pit3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
